// ===== sv/bakery_ticket_arbiter_defines.svh =====
// bakery_ticket_arbiter_defines.svh: assertion macros for the ticket arbiter
// expects signals named clock and reset in the scope of each use
`ifndef BAKERY_TICKET_ARBITER_DEFINES_SVH
`define BAKERY_TICKET_ARBITER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bta_pkg.sv =====
// bta_pkg: shared types and codes of the bakery ticket arbiter
// no dependencies
`default_nettype none

package bta_pkg;

   localparam int KIND_W   = 2;
   localparam int SLOT_FW  = 3;
   localparam int TICKET_FW = 16;
   localparam int STATUS_W = 2;

   // request kinds (the unused code behaves as a poll)
   localparam logic [KIND_W-1:0] KIND_LOCK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POLL   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RELOCK      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_IDLE_UNLOCK = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_SATURATED   = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request word
      logic own_rd;     // read the requesting slot's ticket
      logic scan_clr;   // reset scan counter and accumulators
      logic scan_step;  // one scan step
      logic commit;     // update state and load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_ok;
      logic own_wait;
      logic is_lock;
      logic is_unlock;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/bta_ram.sv =====
// bta_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bta_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bta_datapath.sv =====
// bta_datapath: waiting flags, ticket ram, scan accumulators, response register
// depends on bta_pkg and bta_ram
`default_nettype none

module bta_datapath #(
   parameter int SLOTS       = 8,
   parameter int TICKET_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bta_pkg::cmd_type                cmd,
   output bta_pkg::sts_type                     sts,
   input  wire logic [bta_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [bta_pkg::SLOT_FW-1:0]     req_slot,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_granted,
   output logic      [bta_pkg::TICKET_FW-1:0]   rsp_ticket,
   output logic      [bta_pkg::STATUS_W-1:0]    rsp_status
);

   import bta_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [TICKET_BITS-1:0] TICKET_TOP = {TICKET_BITS{1'b1}};

   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [SLOT_FW-1:0]     slot_ff, slot_in;
   logic [SLOTS-1:0]       waiting_ff, waiting_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TICKET_BITS-1:0] own_ff, own_in;
   logic [TICKET_BITS-1:0] max_ff, max_in;
   logic                   blk_own_ff, blk_own_in;
   logic                   blk_top_ff, blk_top_in;
   logic                   other_ff, other_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [TICKET_FW-1:0]   rsp_ticket_ff, rsp_ticket_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [SLOT_W-1:0]      slot_idx;
   logic [SLOT_W-1:0]      prev_idx;
   logic                   slot_ok;
   logic                   own_wait;
   logic                   is_lock;
   logic                   is_unlock;
   logic                   scan_done;
   logic                   out_free;
   logic                   rd_en;
   logic [SLOT_W-1:0]      rd_addr;
   logic [TICKET_BITS-1:0] rd_data;
   logic                   wr_en;
   logic [TICKET_BITS-1:0] t_j;
   logic                   w_j;
   logic                   sat;
   logic [TICKET_BITS-1:0] new_ticket;

   assign slot_idx  = SLOT_W'(slot_ff);
   assign slot_ok   = 32'(slot_ff) < SLOTS;
   assign own_wait  = slot_ok && waiting_ff[slot_idx];
   assign is_lock   = (kind_ff == KIND_LOCK);
   assign is_unlock = (kind_ff == KIND_UNLOCK);
   assign scan_done = (cnt_ff == CNT_W'(SLOTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign sts = '{slot_ok: slot_ok, own_wait: own_wait, is_lock: is_lock,
                  is_unlock: is_unlock, scan_done: scan_done, out_free: out_free};

   // ticket store; a slot's entry counts only while its waiting flag is set
   assign rd_en   = cmd.own_rd || (cmd.scan_step && !scan_done);
   assign rd_addr = cmd.own_rd ? slot_idx : SLOT_W'(cnt_ff);
   assign wr_en   = cmd.commit && slot_ok && is_lock && !own_wait;

   assign sat        = (max_ff == TICKET_TOP);
   assign new_ticket = sat ? TICKET_TOP : max_ff + TICKET_BITS'(1);

   bta_ram #(
      .WIDTH (TICKET_BITS),
      .DEPTH (SLOTS)
   ) u_tickets (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_idx),
      .wr_data (new_ticket),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry whose read data arrives this scan cycle
   assign prev_idx = SLOT_W'(cnt_ff - CNT_W'(1));
   assign t_j      = waiting_ff[prev_idx] ? rd_data : '0;
   assign w_j      = waiting_ff[prev_idx] && (prev_idx != slot_idx);

   always_comb begin
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      waiting_in     = waiting_ff;
      cnt_in         = cnt_ff;
      own_in         = own_ff;
      max_in         = max_ff;
      blk_own_in     = blk_own_ff;
      blk_top_in     = blk_top_ff;
      other_in       = other_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_ticket_in  = rsp_ticket_ff;
      rsp_status_in  = rsp_status_ff;

      if (cmd.load) begin
         kind_in = req_kind;
         slot_in = req_slot;
      end

      if (cmd.scan_clr) begin
         cnt_in     = '0;
         max_in     = '0;
         blk_own_in = 1'b0;
         blk_top_in = 1'b0;
         other_in   = 1'b0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == '0) begin
            own_in = rd_data;
         end else begin
            if (t_j > max_ff) begin
               max_in = t_j;
            end
            // lower (ticket, slot) pair among other waiting slots
            if (w_j && ((t_j < own_ff) || ((t_j == own_ff) && (prev_idx < slot_idx)))) begin
               blk_own_in = 1'b1;
            end
            if (w_j && ((t_j < TICKET_TOP) ||
                        ((t_j == TICKET_TOP) && (prev_idx < slot_idx)))) begin
               blk_top_in = 1'b1;
            end
            if (w_j) begin
               other_in = 1'b1;
            end
         end
      end

      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = 1'b0;
         rsp_ticket_in  = '0;
         rsp_status_in  = STAT_OK;
         if (slot_ok) begin
            if (is_lock) begin
               if (own_wait) begin
                  rsp_granted_in = !blk_own_ff;
                  rsp_ticket_in  = TICKET_FW'(own_ff);
                  rsp_status_in  = STAT_RELOCK;
               end else begin
                  waiting_in[slot_idx] = 1'b1;
                  rsp_granted_in       = sat ? !blk_top_ff : !other_ff;
                  rsp_ticket_in        = TICKET_FW'(new_ticket);
                  rsp_status_in        = sat ? STAT_SATURATED : STAT_OK;
               end
            end else if (is_unlock) begin
               if (own_wait) begin
                  waiting_in[slot_idx] = 1'b0;
               end else begin
                  rsp_status_in = STAT_IDLE_UNLOCK;
               end
            end else if (own_wait) begin
               rsp_granted_in = !blk_own_ff;
               rsp_ticket_in  = TICKET_FW'(own_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      slot_ff        <= slot_in;
      cnt_ff         <= cnt_in;
      own_ff         <= own_in;
      max_ff         <= max_in;
      blk_own_ff     <= blk_own_in;
      blk_top_ff     <= blk_top_in;
      other_ff       <= other_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_ticket_ff  <= rsp_ticket_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_ticket  = rsp_ticket_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== sv/bta_ctrl.sv =====
// bta_ctrl: sequencing state machine of the ticket arbiter
// depends on bta_pkg
`default_nettype none

module bta_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bta_pkg::sts_type sts,
   output bta_pkg::cmd_type      cmd
);

   import bta_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       need_scan;

   // a scan is needed for a fresh lock, or for any non-unlock of a waiting slot
   assign need_scan = sts.slot_ok &&
                      ((sts.is_lock && !sts.own_wait) || (sts.own_wait && !sts.is_unlock));

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (need_scan) begin
               cmd.own_rd   = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/bakery_ticket_arbiter.sv =====
// bakery_ticket_arbiter: ticket-ordered mutual-exclusion arbiter (bakery lock)
// depends on bta_pkg, bta_ctrl, bta_datapath, bta_ram, bakery_ticket_arbiter_defines.svh
//
// usage
//   req channel: one word names a slot and a kind (lock, unlock, poll); taken
//     on a clock edge with req_valid high and req_stall low
//   rsp channel: exactly one word per request, in order: grant bit, the
//     slot's ticket after the step, and a status code
//   a lock of an idle slot takes the largest ticket plus one (saturating at
//     the top value); an unlock clears the slot; a poll only reports
// sequence
//   lock of an idle slot, and lock or poll of a waiting slot: accept, decode,
//     then a sweep of the ticket ram through its single read port, one entry
//     per cycle, then commit of the result
//   unlock, poll of an idle slot, slot out of range: accept, decode, commit
//   one word in flight; the next request is taken while a result still waits
// reset: synchronous; all slots idle, no result pending, no clearing pass
// stall: rsp holds its word while rsp_stall is high; a finished step waits
//   before committing until the response register is free
`default_nettype none

module bakery_ticket_arbiter #(
   parameter int SLOTS       = 8,
   parameter int TICKET_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bta_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [bta_pkg::SLOT_FW-1:0]   req_slot,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_granted,
   output logic      [bta_pkg::TICKET_FW-1:0] rsp_ticket,
   output logic      [bta_pkg::STATUS_W-1:0]  rsp_status
);

   import bta_pkg::*;

`include "bakery_ticket_arbiter_defines.svh"

   cmd_type cmd;
   sts_type sts;

   // controller: accept, decode, sweep, commit
   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: flags, ticket ram, comparisons, response register
   bta_datapath #(
      .SLOTS       (SLOTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_kind    (req_kind),
      .req_slot    (req_slot),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_granted (rsp_granted),
      .rsp_ticket  (rsp_ticket),
      .rsp_status  (rsp_status)
   );

   // an accepted word keeps the input closed until its result is committed
   `BTA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept while busy")
   // a result never overwrites one still waiting
   `BTA_ASSERT_NOW(a_commit_free, cmd.commit, !rsp_valid || !rsp_stall, "result overwritten")
   // a new result only appears after a commit
   `BTA_ASSERT_NOW(a_rsp_from_commit, $rose(rsp_valid), $past(cmd.commit), "spurious result")
   // the sweep never overlaps taking a new word or committing a result
   `BTA_ASSERT_NOW(a_scan_no_load, cmd.scan_step, !cmd.load && !cmd.commit, "scan overlap")

endmodule

`default_nettype wire
